// ----- rtl/fsp_pkg.sv -----
// Package for the frame scope profiler: sizes, codes, entry layouts and
// saturating arithmetic helpers. No dependencies.
package fsp_pkg;

  localparam int BUCKETS       = 37;
  localparam int WORST_ENTRIES = 20;
  localparam int TIME_BITS     = 48;
  localparam int DEPTH_BITS    = 8;
  localparam int BKT_IDX_BITS  = 6;
  localparam int WST_IDX_BITS  = 5;

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

  typedef enum logic [2:0] {
    REQ_BEGIN_FRAME = 3'd0,
    REQ_END_FRAME   = 3'd1,
    REQ_BEGIN_SCOPE = 3'd2,
    REQ_END_SCOPE   = 3'd3,
    REQ_READ_WORST  = 3'd4,
    REQ_READ_BUCKET = 3'd5,
    REQ_READ_STATS  = 3'd6,
    REQ_NONE        = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    KIND_FRAME     = 3'd0,
    KIND_WORST     = 3'd1,
    KIND_EMPTY     = 3'd2,
    KIND_BUCKET    = 3'd3,
    KIND_STATS     = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    CFG_ENABLE    = 3'd0,
    CFG_BUDGET    = 3'd1,
    CFG_WARN_LOW  = 3'd2,
    CFG_WARN_HIGH = 3'd3,
    CFG_WAIT_BKT  = 3'd4,
    CFG_CAND_MASK = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SC_WR,
    ST_SWEEP,
    ST_CALC,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_WR,
    ST_WST_DATA,
    ST_BKT_DATA,
    ST_OUT
  } state_e;

  // per-bucket state of the open frame
  typedef struct packed {
    logic [DEPTH_BITS-1:0] depth;
    logic [TIME_BITS-1:0]  start;
    logic [TIME_BITS-1:0]  ticks;
  } frm_ent_t;

  // one entry of the ranked worst-frame list
  typedef struct packed {
    logic [31:0]             num;
    logic [TIME_BITS-1:0]    tot;
    logic [TIME_BITS-1:0]    wk;
    logic [BKT_IDX_BITS-1:0] db;
    logic [TIME_BITS-1:0]    dt;
  } wst_ent_t;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [TIME_BITS-1:0] sat_add_t(input logic [TIME_BITS-1:0] a,
                                                     input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
  endfunction

  function automatic logic [TIME_BITS-1:0] excess(input logic [TIME_BITS-1:0] v,
                                                  input logic [TIME_BITS-1:0] bud);
    return (v > bud) ? v - bud : '0;
  endfunction

endpackage

// ----- rtl/fsp_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module fsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- rtl/frame_scope_profiler.sv -----
// Frame scope profiler: one item at a time. A scope event updates its bucket entry,
// a read fills the output register, a begin frame on a closed frame just opens it;
// closing a frame sweeps 37 buckets through the bucket RAMs, updates statistics,
// then walks the worst list (shifting up to 20 entries down one rank) and inserts it.
// Each result then waits in the output register. Reset (async, active low) clears
// control, statistics and per-bucket valid bits. Depends on fsp_pkg and fsp_ram.
module frame_scope_profiler (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   req_type_i,
  input  logic [47:0]                  timestamp_i,
  input  logic [5:0]                   bucket_i,
  input  logic [4:0]                   entry_index_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   kind_o,
  output logic [31:0]                  frame_num_o,
  output logic [63:0]                  total_ticks_o,
  output logic [63:0]                  work_ticks_o,
  output logic [47:0]                  over_budget_ticks_o,
  output logic [47:0]                  work_over_budget_ticks_o,
  output logic [5:0]                   dom_bucket_o,
  output logic [47:0]                  dominant_ticks_o,
  output logic [31:0]                  over_budget_count_o,
  output logic [31:0]                  work_over_count_o,
  output logic [31:0]                  warn_low_count_o,
  output logic [31:0]                  warn_high_count_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [2:0]                   cfg_index_i,
  input  logic [47:0]                  cfg_data_i
);
  import fsp_pkg::*;

  localparam logic [BKT_IDX_BITS-1:0] LAST_BKT = BKT_IDX_BITS'(BUCKETS - 1);

  // configuration
  logic                    enable_q;
  logic [TIME_BITS-1:0]    budget_q, warn_lo_q, warn_hi_q;
  logic [BKT_IDX_BITS-1:0] wait_bkt_q;
  logic [BUCKETS-1:0]      cand_q;

  // control and statistics
  state_e                  state_q, state_d;
  logic                    open_q, open_d;
  logic [TIME_BITS-1:0]    fstart_q, fstart_d;
  logic [31:0]             fcount_q, fcount_d;
  logic [63:0]             sum_tot_q, sum_tot_d, sum_wk_q, sum_wk_d;
  logic [TIME_BITS-1:0]    max_tot_q, max_tot_d, max_wk_q, max_wk_d;
  logic [31:0]             thr_q [4];
  logic [31:0]             thr_d [4];
  logic [WST_IDX_BITS:0]   used_q, used_d;
  logic [BUCKETS-1:0]      vfr_q, vfr_d, vsum_q, vsum_d;

  // latched request and close-frame working registers
  req_e                    req_q, req_d;
  logic [TIME_BITS-1:0]    ts_q, ts_d;
  logic [BKT_IDX_BITS-1:0] b_q, b_d;
  logic                    pend_q, pend_d;
  logic [BKT_IDX_BITS-1:0] cnt_q, cnt_d, pidx_q, pidx_d;
  logic                    pval_q, pval_d;
  logic [BKT_IDX_BITS-1:0] db_q, db_d;
  logic [TIME_BITS-1:0]    dt_q, dt_d, wt_q, wt_d, tot_q, tot_d, wk_q, wk_d;
  logic [WST_IDX_BITS:0]   at_q, at_d;

  // output register
  logic                    ov_q, ov_d;
  logic [2:0]              kind_q, kind_d;
  logic [31:0]             fidx_q, fidx_d;
  logic [63:0]             otot_q, otot_d, owk_q, owk_d;
  logic [TIME_BITS-1:0]    oex_q, oex_d, owex_q, owex_d;
  logic [BKT_IDX_BITS-1:0] odb_q, odb_d;
  logic [TIME_BITS-1:0]    odt_q, odt_d;
  logic [31:0]             oc_q [4];
  logic [31:0]             oc_d [4];

  // memories
  logic                    fr_we, fr_re, sm_we, wst_we, wst_re;
  logic [BKT_IDX_BITS-1:0] fr_waddr, bk_raddr, sm_waddr;
  frm_ent_t                fr_wdata, fr_rdata, fr_cur, fr_new;
  logic [63:0]             sm_wdata, sm_rdata;
  logic [WST_IDX_BITS-1:0] wst_waddr, wst_raddr;
  wst_ent_t                wst_wdata, wst_rdata;

  logic                    in_acc;
  logic [TIME_BITS-1:0]    sw_ticks, cl_wk;

  fsp_ram #(.WIDTH($bits(frm_ent_t)), .DEPTH(BUCKETS)) u_frm_ram (
    .clk_i, .we_i(fr_we), .waddr_i(fr_waddr), .wdata_i(fr_wdata),
    .re_i(fr_re), .raddr_i(bk_raddr), .rdata_o(fr_rdata)
  );

  fsp_ram #(.WIDTH(64), .DEPTH(BUCKETS)) u_sum_ram (
    .clk_i, .we_i(sm_we), .waddr_i(sm_waddr), .wdata_i(sm_wdata),
    .re_i(fr_re), .raddr_i(bk_raddr), .rdata_o(sm_rdata)
  );

  fsp_ram #(.WIDTH($bits(wst_ent_t)), .DEPTH(WORST_ENTRIES)) u_wst_ram (
    .clk_i, .we_i(wst_we), .waddr_i(wst_waddr), .wdata_i(wst_wdata),
    .re_i(wst_re), .raddr_i(wst_raddr), .rdata_o(wst_rdata)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && !in_stall_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      budget_q   <= TIME_BITS'(33333);
      warn_lo_q  <= TIME_BITS'(40000);
      warn_hi_q  <= TIME_BITS'(50000);
      wait_bkt_q <= BKT_IDX_BITS'(35);
      cand_q     <= 37'd103062278141;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ENABLE:    enable_q   <= cfg_data_i[0];
        CFG_BUDGET:    budget_q   <= cfg_data_i;
        CFG_WARN_LOW:  warn_lo_q  <= cfg_data_i;
        CFG_WARN_HIGH: warn_hi_q  <= cfg_data_i;
        CFG_WAIT_BKT:  wait_bkt_q <= cfg_data_i[BKT_IDX_BITS-1:0];
        CFG_CAND_MASK: cand_q     <= cfg_data_i[BUCKETS-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (req_type_i)
            REQ_BEGIN_FRAME: if (enable_q && open_q) state_d = ST_SWEEP;
            REQ_END_FRAME:   if (enable_q && open_q) state_d = ST_SWEEP;
            REQ_BEGIN_SCOPE, REQ_END_SCOPE: begin
              if (enable_q && open_q && bucket_i < BKT_IDX_BITS'(BUCKETS)) state_d = ST_SC_WR;
            end
            REQ_READ_WORST: begin
              state_d = ({1'b0, entry_index_i} < used_q) ? ST_WST_DATA : ST_OUT;
            end
            REQ_READ_BUCKET: begin
              state_d = (bucket_i < BKT_IDX_BITS'(BUCKETS)) ? ST_BKT_DATA : ST_OUT;
            end
            REQ_READ_STATS: state_d = ST_OUT;
            default: ;
          endcase
        end
      end
      ST_SC_WR:    state_d = ST_IDLE;
      ST_SWEEP:    if (pval_q && pidx_q == LAST_BKT) state_d = ST_CALC;
      ST_CALC:     state_d = ST_INS_RD;
      ST_INS_RD:   state_d = (at_q == '0) ? ST_INS_WR : ST_INS_CMP;
      ST_INS_CMP:  state_d = (wk_q > wst_rdata.wk) ? ST_INS_RD : ST_INS_WR;
      ST_INS_WR:   state_d = ST_OUT;
      ST_WST_DATA: state_d = ST_OUT;
      ST_BKT_DATA: state_d = ST_OUT;
      ST_OUT:      if (!out_stall_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // memory addressing
  assign bk_raddr  = (state_q == ST_SWEEP) ? cnt_q : bucket_i;
  assign fr_re     = (state_q == ST_SWEEP && cnt_q < BKT_IDX_BITS'(BUCKETS)) ||
                     (state_q == ST_IDLE && in_acc && bucket_i < BKT_IDX_BITS'(BUCKETS));
  assign wst_raddr = (state_q == ST_INS_RD) ? WST_IDX_BITS'(at_q - 1'b1) : entry_index_i;
  assign wst_re    = (state_q == ST_INS_RD) || (state_q == ST_IDLE && in_acc);

  assign fr_cur   = vfr_q[b_q] ? fr_rdata : '0;
  assign sw_ticks = vfr_q[pidx_q] ? fr_rdata.ticks : '0;
  assign cl_wk    = (wait_bkt_q < BKT_IDX_BITS'(BUCKETS)) ?
                    ((tot_q > wt_q) ? tot_q - wt_q : '0) : tot_q;

  // scope update of one bucket entry
  always_comb begin
    fr_new = fr_cur;
    if (req_q == REQ_BEGIN_SCOPE) begin
      if (fr_cur.depth != DEPTH_MAX) begin
        fr_new.depth = fr_cur.depth + 1'b1;
        if (fr_cur.depth == '0) fr_new.start = ts_q;
      end
    end else if (fr_cur.depth != '0) begin
      fr_new.depth = fr_cur.depth - 1'b1;
      if (fr_new.depth == '0) fr_new.ticks = sat_add_t(fr_cur.ticks, ts_q - fr_cur.start);
    end
  end

  // datapath
  always_comb begin
    open_d = open_q;  fstart_d = fstart_q;  fcount_d = fcount_q;
    sum_tot_d = sum_tot_q;  sum_wk_d = sum_wk_q;
    max_tot_d = max_tot_q;  max_wk_d = max_wk_q;
    thr_d = thr_q;  used_d = used_q;  vfr_d = vfr_q;  vsum_d = vsum_q;
    req_d = req_q;  ts_d = ts_q;  b_d = b_q;  pend_d = pend_q;
    cnt_d = cnt_q;  pidx_d = pidx_q;  pval_d = 1'b0;
    db_d = db_q;  dt_d = dt_q;  wt_d = wt_q;  tot_d = tot_q;  wk_d = wk_q;  at_d = at_q;
    ov_d = ov_q;  kind_d = kind_q;  fidx_d = fidx_q;  otot_d = otot_q;  owk_d = owk_q;
    oex_d = oex_q;  owex_d = owex_q;  odb_d = odb_q;  odt_d = odt_q;  oc_d = oc_q;
    fr_we = 1'b0;  fr_waddr = b_q;  fr_wdata = fr_new;
    sm_we = 1'b0;  sm_waddr = pidx_q;
    sm_wdata = sat_add64(vsum_q[pidx_q] ? sm_rdata : '0, {16'd0, sw_ticks});
    wst_we = 1'b0;  wst_waddr = at_q[WST_IDX_BITS-1:0];  wst_wdata = wst_rdata;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          req_d = req_e'(req_type_i);  ts_d = timestamp_i;  b_d = bucket_i;
          cnt_d = '0;  db_d = '0;  dt_d = '0;  wt_d = '0;
          tot_d = timestamp_i - fstart_q;
          pend_d = (req_type_i == REQ_BEGIN_FRAME);
          // every non-frame field of a result is zero unless filled below
          fidx_d = '0;  otot_d = '0;  owk_d = '0;  oex_d = '0;  owex_d = '0;
          odb_d = '0;  odt_d = '0;  oc_d = '{default: '0};
          unique case (req_type_i)
            REQ_BEGIN_FRAME: begin
              if (enable_q && !open_q) begin
                vfr_d = '0;  fstart_d = timestamp_i;  open_d = 1'b1;
              end
            end
            REQ_READ_WORST: begin
              kind_d = KIND_EMPTY;
              if (!({1'b0, entry_index_i} < used_q)) ov_d = 1'b1;
            end
            REQ_READ_BUCKET: begin
              kind_d = KIND_BUCKET;
              if (!(bucket_i < BKT_IDX_BITS'(BUCKETS))) ov_d = 1'b1;
            end
            REQ_READ_STATS: begin
              ov_d = 1'b1;  kind_d = KIND_STATS;  fidx_d = fcount_q;
              otot_d = sum_tot_q;  owk_d = sum_wk_q;
              oex_d = max_tot_q;  owex_d = max_wk_q;  oc_d = thr_q;
            end
            default: ;
          endcase
        end
      end
      ST_SC_WR: begin
        fr_we = 1'b1;
        vfr_d[b_q] = 1'b1;
      end
      ST_SWEEP: begin
        // read one bucket a cycle, fold the one read last cycle
        if (cnt_q < BKT_IDX_BITS'(BUCKETS)) begin
          pval_d = 1'b1;  pidx_d = cnt_q;  cnt_d = cnt_q + 1'b1;
        end
        if (pval_q) begin
          sm_we = 1'b1;
          vsum_d[pidx_q] = 1'b1;
          if (cand_q[pidx_q] && sw_ticks > dt_q) begin
            db_d = pidx_q;  dt_d = sw_ticks;
          end
          if (pidx_q == wait_bkt_q) wt_d = sw_ticks;
        end
      end
      ST_CALC: begin
        wk_d = cl_wk;
        sum_tot_d = sat_add64(sum_tot_q, {16'd0, tot_q});
        sum_wk_d  = sat_add64(sum_wk_q, {16'd0, cl_wk});
        if (tot_q > max_tot_q) max_tot_d = tot_q;
        if (cl_wk > max_wk_q)  max_wk_d = cl_wk;
        if (tot_q > budget_q  && thr_q[0] != '1) thr_d[0] = thr_q[0] + 1'b1;
        if (cl_wk > budget_q  && thr_q[1] != '1) thr_d[1] = thr_q[1] + 1'b1;
        if (tot_q > warn_lo_q && thr_q[2] != '1) thr_d[2] = thr_q[2] + 1'b1;
        if (tot_q > warn_hi_q && thr_q[3] != '1) thr_d[3] = thr_q[3] + 1'b1;
        kind_d = KIND_FRAME;  fidx_d = fcount_q;
        otot_d = {16'd0, tot_q};  owk_d = {16'd0, cl_wk};
        oex_d = excess(tot_q, budget_q);  owex_d = excess(cl_wk, budget_q);
        odb_d = db_q;  odt_d = dt_q;
        fcount_d = fcount_q + 1'b1;
        open_d = 1'b0;
        at_d = used_q;
      end
      ST_INS_CMP: begin
        // move the smaller entry down one rank
        if (wk_q > wst_rdata.wk) begin
          if (at_q < (WST_IDX_BITS+1)'(WORST_ENTRIES)) wst_we = 1'b1;
          at_d = at_q - 1'b1;
        end
      end
      ST_INS_WR: begin
        wst_wdata = '{num: fidx_q, tot: tot_q, wk: wk_q, db: db_q, dt: dt_q};
        if (at_q < (WST_IDX_BITS+1)'(WORST_ENTRIES)) wst_we = 1'b1;
        if (used_q < (WST_IDX_BITS+1)'(WORST_ENTRIES)) used_d = used_q + 1'b1;
        if (pend_q) begin
          vfr_d = '0;  fstart_d = ts_q;  open_d = 1'b1;
        end
        ov_d = 1'b1;
      end
      ST_WST_DATA: begin
        ov_d = 1'b1;  kind_d = KIND_WORST;  fidx_d = wst_rdata.num;
        otot_d = {16'd0, wst_rdata.tot};  owk_d = {16'd0, wst_rdata.wk};
        oex_d = excess(wst_rdata.tot, budget_q);  owex_d = excess(wst_rdata.wk, budget_q);
        odb_d = wst_rdata.db;  odt_d = wst_rdata.dt;
      end
      ST_BKT_DATA: begin
        ov_d = 1'b1;
        otot_d = vsum_q[b_q] ? sm_rdata : '0;
      end
      ST_OUT: begin
        if (!out_stall_i) ov_d = 1'b0;
      end
      default: ;
    endcase
  end

  // control and statistics registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;  open_q <= 1'b0;  fstart_q <= '0;  fcount_q <= '0;
      sum_tot_q <= '0;  sum_wk_q <= '0;  max_tot_q <= '0;  max_wk_q <= '0;
      thr_q <= '{default: '0};  used_q <= '0;  vfr_q <= '0;  vsum_q <= '0;
      pval_q <= 1'b0;  ov_q <= 1'b0;  pend_q <= 1'b0;  req_q <= REQ_NONE;
      cnt_q <= '0;  at_q <= '0;
    end else begin
      state_q <= state_d;  open_q <= open_d;  fstart_q <= fstart_d;  fcount_q <= fcount_d;
      sum_tot_q <= sum_tot_d;  sum_wk_q <= sum_wk_d;
      max_tot_q <= max_tot_d;  max_wk_q <= max_wk_d;
      thr_q <= thr_d;  used_q <= used_d;  vfr_q <= vfr_d;  vsum_q <= vsum_d;
      pval_q <= pval_d;  ov_q <= ov_d;  pend_q <= pend_d;  req_q <= req_d;
      cnt_q <= cnt_d;  at_q <= at_d;
    end
  end

  // working and output payload registers
  always_ff @(posedge clk_i) begin
    ts_q <= ts_d;  b_q <= b_d;  pidx_q <= pidx_d;  db_q <= db_d;  dt_q <= dt_d;
    wt_q <= wt_d;  tot_q <= tot_d;  wk_q <= wk_d;
    kind_q <= kind_d;  fidx_q <= fidx_d;  otot_q <= otot_d;  owk_q <= owk_d;
    oex_q <= oex_d;  owex_q <= owex_d;  odb_q <= odb_d;  odt_q <= odt_d;  oc_q <= oc_d;
  end

  assign out_valid_o              = ov_q;
  assign kind_o                   = kind_q;
  assign frame_num_o              = fidx_q;
  assign total_ticks_o            = otot_q;
  assign work_ticks_o             = owk_q;
  assign over_budget_ticks_o      = oex_q;
  assign work_over_budget_ticks_o = owex_q;
  assign dom_bucket_o             = odb_q;
  assign dominant_ticks_o         = odt_q;
  assign over_budget_count_o      = oc_q[0];
  assign work_over_count_o        = oc_q[1];
  assign warn_low_count_o         = oc_q[2];
  assign warn_high_count_o        = oc_q[3];

endmodule

// ----- rtl/fsp_checker.sv -----
// Port-level checks for the frame scope profiler, bound to the top level.
// Depends on fsp_pkg and frame_scope_profiler.
module fsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  kind_o,
  input logic [63:0] total_ticks_o
);
  import fsp_pkg::*;

  // a waiting word holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o))
    else $error("output word dropped or changed while stalled");

  // no new item is taken while a result is pending
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while result pending");

  // result kind is a defined code
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o == KIND_FRAME || kind_o == KIND_WORST ||
                     kind_o == KIND_EMPTY || kind_o == KIND_BUCKET || kind_o == KIND_STATS))
    else $error("undefined result kind");

  // empty worst slot carries zero totals
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_EMPTY |-> total_ticks_o == '0)
    else $error("empty slot with nonzero total");

endmodule

bind frame_scope_profiler fsp_checker u_fsp_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i, .kind_o, .total_ticks_o
);
